### rtl/bstd_pkg.sv
// ----------------------------------------------------------------------------
// bstd_pkg
// Shared widths, weight codes and pipeline control type for the block-scaled
// ternary dot unit.
// ----------------------------------------------------------------------------
package bstd_pkg;

  // Field widths.
  localparam int ACT_WIDTH       = 16;
  localparam int LANES           = 4;
  localparam int CODE_W          = 2;
  localparam int LANES_VALID_W   = 3;
  localparam int SCALE_W         = 16;
  localparam int SCALE_FRAC_BITS = 12;
  localparam int OUT_W           = 48;

  // Internal accumulator widths.
  localparam int LANE_PROD_W = ACT_WIDTH + 2;
  localparam int LANE_SUM_W  = LANE_PROD_W + 2;
  localparam int BLOCK_ACC_W = 25;
  localparam int FOLD_W      = BLOCK_ACC_W + SCALE_W;
  localparam int ROW_ACC_W   = 64;
  localparam int SHIFT_W     = ROW_ACC_W - SCALE_FRAC_BITS;

  // Weight codes: the weight is the code minus one.
  typedef enum logic [CODE_W-1:0] {
    CODE_NEG  = 2'd0,
    CODE_ZERO = 2'd1,
    CODE_POS  = 2'd2,
    CODE_DBL  = 2'd3
  } code_t;

  // Control flags that travel down the pipeline beside the data.
  typedef struct packed {
    logic valid;
    logic blk_last;
    logic row_end;
  } bstd_ctl_t;

endpackage

### rtl/bstd_if.sv
// ----------------------------------------------------------------------------
// bstd_if
// Valid/ready channels for the dot unit: the input beat and the result beat.
// ----------------------------------------------------------------------------
interface bstd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] act0;
  logic signed [15:0] act1;
  logic signed [15:0] act2;
  logic signed [15:0] act3;
  logic        [7:0]  code_byte;
  logic        [2:0]  lanes_valid;
  logic signed [15:0] block_scale;
  logic               block_last;
  logic               row_last;

  modport source (
    output valid, act0, act1, act2, act3, code_byte, lanes_valid, block_scale,
           block_last, row_last,
    input  ready
  );
  modport sink (
    input  valid, act0, act1, act2, act3, code_byte, lanes_valid, block_scale,
           block_last, row_last,
    output ready
  );
endinterface

interface bstd_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] row_sum;
  logic               saturated;

  modport source (output valid, row_sum, saturated, input ready);
  modport sink (input valid, row_sum, saturated, output ready);
endinterface

### rtl/bstd_lane.sv
// ----------------------------------------------------------------------------
// bstd_lane
// One multiply lane: applies a ternary-plus-two weight to an activation and
// registers the product.
// ----------------------------------------------------------------------------
module bstd_lane
  import bstd_pkg::*;
(
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [ACT_WIDTH-1:0]   act,
  input  logic        [CODE_W-1:0]      code,
  input  logic                          lane_on,
  output logic signed [LANE_PROD_W-1:0] prod
);

  logic signed [LANE_PROD_W-1:0] act_ext;
  logic signed [LANE_PROD_W-1:0] prod_next;

  assign act_ext = LANE_PROD_W'(act);

  // Weight select: -a, 0, +a or +2a; lanes beyond the valid count add nothing.
  always_comb begin
    prod_next = '0;
    if (lane_on) begin
      case (code_t'(code))
        CODE_NEG:  prod_next = -act_ext;
        CODE_ZERO: prod_next = '0;
        CODE_POS:  prod_next = act_ext;
        CODE_DBL:  prod_next = act_ext <<< 1;
        default:   prod_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
    end
  end

endmodule

### rtl/bstd_blk_acc.sv
// ----------------------------------------------------------------------------
// bstd_blk_acc
// Merges the lane products and keeps the running block sum; at block or row
// end the finished block total is handed on and the sum starts again.
// ----------------------------------------------------------------------------
module bstd_blk_acc
  import bstd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  bstd_ctl_t                     ctl_in,
  input  logic signed [LANE_PROD_W-1:0] prod [LANES],
  input  logic signed [SCALE_W-1:0]     scale_in,
  output bstd_ctl_t                     ctl_out,
  output logic signed [BLOCK_ACC_W-1:0] blk_total,
  output logic signed [SCALE_W-1:0]     scale_out
);

  logic signed [BLOCK_ACC_W-1:0] block_acc;
  logic signed [LANE_SUM_W-1:0]  pair0;
  logic signed [LANE_SUM_W-1:0]  pair1;
  logic signed [LANE_SUM_W-1:0]  lane_sum;
  logic signed [BLOCK_ACC_W-1:0] total;
  logic                          fold;

  // Two-level adder tree over the lanes, then the block sum wraps at its width.
  assign pair0    = LANE_SUM_W'(prod[0]) + LANE_SUM_W'(prod[1]);
  assign pair1    = LANE_SUM_W'(prod[2]) + LANE_SUM_W'(prod[3]);
  assign lane_sum = pair0 + pair1;
  assign total    = block_acc + BLOCK_ACC_W'(lane_sum);
  assign fold     = ctl_in.blk_last || ctl_in.row_end;

  // Running block sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_acc <= '0;
    end else if (en && ctl_in.valid) begin
      block_acc <= fold ? '0 : total;
    end
  end

  // Hand-off register towards the scaling stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out.valid    <= ctl_in.valid && fold;
      ctl_out.blk_last <= ctl_in.blk_last;
      ctl_out.row_end  <= ctl_in.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blk_total <= total;
      scale_out <= scale_in;
    end
  end

  // A folded block leaves a cleared sum behind.
  a_blk_cleared: assert property (@(posedge clk) disable iff (rst)
    (en && ctl_in.valid && fold) |=> (block_acc == '0))
    else $error("block sum not cleared after block end");

endmodule

### rtl/bstd_row_acc.sv
// ----------------------------------------------------------------------------
// bstd_row_acc
// Scales each finished block total, adds it into the saturating row sum and
// presents the completed row value at row end.
// ----------------------------------------------------------------------------
module bstd_row_acc
  import bstd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  bstd_ctl_t                     ctl_in,
  input  logic signed [BLOCK_ACC_W-1:0] blk_total,
  input  logic signed [SCALE_W-1:0]     scale,
  output logic                          fin_valid,
  output logic signed [ROW_ACC_W-1:0]   fin_acc,
  output logic                          fin_ovf
);

  localparam logic [ROW_ACC_W-1:0] ACC_MAX = {1'b0, {(ROW_ACC_W-1){1'b1}}};
  localparam logic [ROW_ACC_W-1:0] ACC_MIN = {1'b1, {(ROW_ACC_W-1){1'b0}}};

  bstd_ctl_t                   ctl_a;
  logic signed [FOLD_W-1:0]    fold_prod;
  logic signed [ROW_ACC_W-1:0] row_acc;
  logic                        row_overflow;
  logic        [ROW_ACC_W:0]   sum_ext;
  logic                        add_ovf;
  logic signed [ROW_ACC_W-1:0] acc_new;
  logic                        ovf_new;

  // Scaling multiply, registered on its own.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (en) begin
      ctl_a <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fold_prod <= blk_total * scale;
    end
  end

  // Saturating add: a carry into the extra bit that disagrees with the sign
  // means the 64-bit sum overflowed.
  assign sum_ext = {row_acc[ROW_ACC_W-1], row_acc}
                 + {{(ROW_ACC_W+1-FOLD_W){fold_prod[FOLD_W-1]}}, fold_prod};
  assign add_ovf = sum_ext[ROW_ACC_W] ^ sum_ext[ROW_ACC_W-1];
  assign acc_new = add_ovf ? (sum_ext[ROW_ACC_W] ? ACC_MIN : ACC_MAX)
                           : sum_ext[ROW_ACC_W-1:0];
  assign ovf_new = row_overflow || add_ovf;

  // Row sum and overflow flag; both restart once a row is handed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc      <= '0;
      row_overflow <= 1'b0;
    end else if (en && ctl_a.valid) begin
      if (ctl_a.row_end) begin
        row_acc      <= '0;
        row_overflow <= 1'b0;
      end else begin
        row_acc      <= acc_new;
        row_overflow <= ovf_new;
      end
    end
  end

  // Completed row value.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= ctl_a.valid && ctl_a.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_acc <= acc_new;
      fin_ovf <= ovf_new;
    end
  end

  // A row end leaves the row sum and its overflow flag cleared.
  a_row_cleared: assert property (@(posedge clk) disable iff (rst)
    (en && ctl_a.valid && ctl_a.row_end) |=> (row_acc == '0 && !row_overflow))
    else $error("row sum not cleared after row end");

  // An overflow seen while adding is carried into the finished row.
  a_ovf_carried: assert property (@(posedge clk) disable iff (rst)
    (en && ctl_a.valid && ctl_a.row_end && add_ovf) |=> (fin_valid && fin_ovf))
    else $error("row overflow lost at row end");

endmodule

### rtl/block_scaled_ternary_dot_unit.sv
// ----------------------------------------------------------------------------
// block_scaled_ternary_dot_unit
// Top level: four weight lanes, block merge, scaled row accumulation and the
// output register.
// ----------------------------------------------------------------------------
// The unit takes one beat per clock unless stalled: a weight byte with four
// activations. Four lanes form the weighted products in parallel, an adder
// tree merges them into the block sum, the block total is scaled by a 25x16
// multiplier and added into the 64-bit row sum, and the row result is clipped
// into a result register behind the lane, block, scaling and row registers.
// Input ready drops only when a finished row sits unread in the result
// register and the next row-end beat has reached the last stage; otherwise
// beats keep flowing while a result waits.
module block_scaled_ternary_dot_unit
  import bstd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bstd_in_if.sink    item,
  bstd_out_if.source result
);

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic                          en;
  bstd_ctl_t                     ctl_in;
  bstd_ctl_t                     ctl_s1;
  bstd_ctl_t                     ctl_s2;
  logic signed [ACT_WIDTH-1:0]   acts   [LANES];
  logic signed [LANE_PROD_W-1:0] prods  [LANES];
  logic signed [SCALE_W-1:0]     scale_s1;
  logic signed [SCALE_W-1:0]     scale_s2;
  logic signed [BLOCK_ACC_W-1:0] blk_total;
  logic                          fin_valid;
  logic signed [ROW_ACC_W-1:0]   fin_acc;
  logic                          fin_ovf;
  logic signed [SHIFT_W-1:0]     shifted;
  logic                          fits;
  logic        [OUT_W-1:0]       clip_val;
  logic                          clip_sat;

  // The pipeline holds only when a new row result meets an unread one.
  assign en         = !(fin_valid && result.valid && !result.ready);
  assign item.ready = en;

  assign ctl_in.valid    = item.valid && item.ready;
  assign ctl_in.blk_last = item.block_last;
  assign ctl_in.row_end  = item.row_last;

  assign acts[0] = item.act0;
  assign acts[1] = item.act1;
  assign acts[2] = item.act2;
  assign acts[3] = item.act3;

  // Lane stage.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bstd_lane u_lane (
      .clk     (clk),
      .en      (en),
      .act     (acts[i]),
      .code    (item.code_byte[CODE_W*(LANES-i)-1 -: CODE_W]),
      .lane_on (item.lanes_valid > LANES_VALID_W'(i)),
      .prod    (prods[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s1 <= '0;
    end else if (en) begin
      ctl_s1 <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scale_s1 <= item.block_scale;
    end
  end

  // Merge stage and block sum.
  bstd_blk_acc u_blk (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl_in    (ctl_s1),
    .prod      (prods),
    .scale_in  (scale_s1),
    .ctl_out   (ctl_s2),
    .blk_total (blk_total),
    .scale_out (scale_s2)
  );

  // Scaling and row sum.
  bstd_row_acc u_row (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl_in    (ctl_s2),
    .blk_total (blk_total),
    .scale     (scale_s2),
    .fin_valid (fin_valid),
    .fin_acc   (fin_acc),
    .fin_ovf   (fin_ovf)
  );

  // Arithmetic shift rounds toward minus infinity; then clip to the output.
  assign shifted  = fin_acc[ROW_ACC_W-1:SCALE_FRAC_BITS];
  assign fits     = (shifted[SHIFT_W-1:OUT_W-1] == {(SHIFT_W-OUT_W+1){shifted[OUT_W-1]}});
  assign clip_val = fits ? shifted[OUT_W-1:0] : (shifted[SHIFT_W-1] ? OUT_MIN : OUT_MAX);
  assign clip_sat = fin_ovf || !fits;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en && fin_valid) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && fin_valid) begin
      result.row_sum   <= clip_val;
      result.saturated <= clip_sat;
    end
  end

  // Input stalls only behind an unread result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (result.valid && !result.ready && fin_valid))
    else $error("input stalled without a blocked result");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result pending after reset");

  // A stalled row result is still waiting on the next cycle.
  a_fin_held: assert property (@(posedge clk) disable iff (rst)
    (fin_valid && !en) |=> fin_valid)
    else $error("row result dropped while stalled");

endmodule
